@@ sv/tcw_pkg.sv @@
// Shared types, codes and microcode store of the text console writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

   localparam logic [15:0] RESET_BLANK_CELL = 16'h0720;
   localparam logic [7:0]  SPACE_CODE       = 8'h20;
   localparam logic [7:0]  NEWLINE_CODE     = 8'h0A;
   localparam logic [7:0]  TEXT_ATTR_RESET  = 8'h07;

   // Register index as decoded from the word address.
   localparam logic CSR_TEXT_ATTRIBUTE = 1'b0;

   typedef enum logic [1:0] {
      KIND_PUT   = 2'd0,
      KIND_READ  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_INIT_FILL,
      ST_IDLE,
      ST_PUT,
      ST_FINISH,
      ST_READ,
      ST_READ_CAP,
      ST_CLR0,
      ST_CLR_FILL,
      ST_SCR0,
      ST_SCR_COPY,
      ST_SCR_FLUSH,
      ST_SCR_BLANK
   } step_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_ZERO,
      PTR_INC,
      PTR_SRC_START,
      PTR_LAST_ROW
   } ptr_op_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_RESET_BLANK,
      WR_ATTR_BLANK,
      WR_CHAR,
      WR_COPY
   } wr_sel_type;

   typedef enum logic {
      RD_PTR,
      RD_CELL
   } rd_sel_type;

   typedef enum logic [1:0] {
      CUR_HOLD,
      CUR_PUT,
      CUR_HOME
   } cur_op_type;

   typedef enum logic [2:0] {
      BR_NEXT,
      BR_GOTO,
      BR_LOOP,
      BR_DISPATCH,
      BR_SCROLL,
      BR_EMIT
   } br_type;

   typedef struct packed {
      ptr_op_type ptr_op;
      wr_sel_type wr_sel;
      rd_sel_type rd_sel;
      cur_op_type cur_op;
      logic       accept;
      logic       copy_rd;
      logic       load_cell;
      logic       emit;
      br_type     br;
      step_type   target;
   } ctrl_word_type;

   typedef struct packed {
      logic     req_valid;
      kind_type kind;
      logic     ptr_last;
      logic     scroll;
      logic     out_free;
   } status_type;

   localparam ctrl_word_type NOP_WORD = '{
      ptr_op:    PTR_HOLD,
      wr_sel:    WR_NONE,
      rd_sel:    RD_PTR,
      cur_op:    CUR_HOLD,
      accept:    1'b0,
      copy_rd:   1'b0,
      load_cell: 1'b0,
      emit:      1'b0,
      br:        BR_NEXT,
      target:    ST_IDLE
   };

   // Microprogram: one control word per step.
   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type w;
      w = NOP_WORD;
      unique case (step)
         ST_INIT: begin
            w.ptr_op = PTR_ZERO;
         end
         ST_INIT_FILL: begin
            w.wr_sel = WR_RESET_BLANK;
            w.ptr_op = PTR_INC;
            w.br     = BR_LOOP;
            w.target = ST_IDLE;
         end
         ST_IDLE: begin
            w.accept = 1'b1;
            w.br     = BR_DISPATCH;
         end
         ST_PUT: begin
            w.wr_sel = WR_CHAR;
            w.cur_op = CUR_PUT;
            w.br     = BR_SCROLL;
            w.target = ST_SCR0;
         end
         ST_FINISH: begin
            w.emit   = 1'b1;
            w.br     = BR_EMIT;
            w.target = ST_IDLE;
         end
         ST_READ: begin
            w.rd_sel = RD_CELL;
         end
         ST_READ_CAP: begin
            w.load_cell = 1'b1;
            w.br        = BR_GOTO;
            w.target    = ST_FINISH;
         end
         ST_CLR0: begin
            w.ptr_op = PTR_ZERO;
            w.cur_op = CUR_HOME;
         end
         ST_CLR_FILL: begin
            w.wr_sel = WR_ATTR_BLANK;
            w.ptr_op = PTR_INC;
            w.br     = BR_LOOP;
            w.target = ST_FINISH;
         end
         ST_SCR0: begin
            w.ptr_op = PTR_SRC_START;
         end
         ST_SCR_COPY: begin
            w.copy_rd = 1'b1;
            w.wr_sel  = WR_COPY;
            w.ptr_op  = PTR_INC;
            w.br      = BR_LOOP;
            w.target  = ST_SCR_FLUSH;
         end
         ST_SCR_FLUSH: begin
            w.wr_sel = WR_COPY;
            w.ptr_op = PTR_LAST_ROW;
         end
         ST_SCR_BLANK: begin
            w.wr_sel = WR_ATTR_BLANK;
            w.ptr_op = PTR_INC;
            w.br     = BR_LOOP;
            w.target = ST_FINISH;
         end
         default: begin
            w.br     = BR_GOTO;
            w.target = ST_IDLE;
         end
      endcase
      return w;
   endfunction

   // Entry step for each request kind.
   function automatic step_type dispatch_step(input kind_type kind);
      step_type s;
      s = ST_FINISH;
      unique case (kind)
         KIND_PUT:   s = ST_PUT;
         KIND_READ:  s = ST_READ;
         KIND_CLEAR: s = ST_CLR0;
         default:    s = ST_FINISH;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

@@ sv/text_console_writer.sv @@
// Top level of the text console writer: screen store, cursor, CSR and response register.
`timescale 1ns / 1ps
`default_nettype none

//  channel   dir   handshake                 payload
//  req_*     in    req_tvalid / req_tready   kind, char_code, read_row, read_col
//  rsp_*     out   rsp_tvalid / rsp_tready   cell_value, cursor_row, cursor_col, scrolled
//  csr_*     in    APB psel/penable/pready   text_attribute at word 0
//
//  A clear walks every cell; a put that scrolls copies the screen up one row,
//  one cell per cycle through the single screen RAM port pair, then blanks
//  the last row. After reset a clearing pass fills the screen with blanks;
//  no request is taken then, CSR writes are.
//  A pending response does not block the next request; the sequencer only
//  waits at its finish step while the response register is still full.

module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: kind[1:0], char_code[9:2], read_row[14:10], read_col[21:15], zero fill
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,
   // rsp_tdata: cell_value[15:0], cursor_row[20:16], cursor_col[27:21], scrolled[28], zero fill
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   import tcw_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS);

   localparam logic [AW-1:0] LAST_ADDR     = AW'(CELLS - 1);
   localparam logic [AW-1:0] ROW_STEP      = AW'(COLUMNS);
   localparam logic [AW-1:0] LAST_ROW_BASE = AW'((ROWS - 1) * COLUMNS);
   localparam logic [RW-1:0] LAST_ROW      = RW'(ROWS - 1);
   localparam logic [CW-1:0] LAST_COL      = CW'(COLUMNS - 1);

   ctrl_word_type ctrl;
   status_type    status;

   // Request fields as they arrive on the bus.
   kind_type     req_kind;
   logic [7:0]   req_char;
   logic [4:0]   req_row;
   logic [6:0]   req_col;
   logic         req_fire;

   // Datapath registers.
   logic [7:0]    attr_ff;
   logic [AW-1:0] ptr_ff,      ptr_in;
   logic [RW-1:0] cur_row_ff,  cur_row_in;
   logic [CW-1:0] cur_col_ff,  cur_col_in;
   logic [AW-1:0] cur_addr_ff, cur_addr_in;
   logic [AW-1:0] row_base_ff, row_base_in;
   logic [7:0]    char_ff;
   logic [4:0]    read_row_ff;
   logic [6:0]    read_col_ff;
   logic          scrolled_ff;
   logic [15:0]   cell_ff;
   logic          copy_pend_ff;
   logic [AW-1:0] dst_ff;
   logic          rsp_valid_ff;
   logic [31:0]   rsp_data_ff;

   // Cursor unit and read addressing.
   logic          put_newline;
   logic          put_wrap;
   logic          put_scroll;
   logic          rd_in_range;
   logic [AW-1:0] cell_addr;
   logic          out_free;
   logic          emit_fire;
   logic          csr_write;

   // Screen RAM ports.
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [15:0]   ram_wr_data;
   logic [AW-1:0] ram_rd_addr;
   logic [15:0]   ram_rd_data;

   // Response field sizing.
   logic [RW+4:0] rsp_row_wide;
   logic [CW+6:0] rsp_col_wide;

   assign req_kind = kind_type'(req_tdata[1:0]);
   assign req_char = req_tdata[9:2];
   assign req_row  = req_tdata[14:10];
   assign req_col  = req_tdata[21:15];

   assign req_tready = ctrl.accept;
   assign req_fire   = req_tvalid && ctrl.accept;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit_fire = ctrl.emit && out_free;

   assign status.req_valid = req_tvalid;
   assign status.kind      = req_kind;
   assign status.ptr_last  = (ptr_ff == LAST_ADDR);
   assign status.scroll    = put_scroll;
   assign status.out_free  = out_free;

   tcw_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // Cursor step for a put: newline or last column wraps, wrap on last row scrolls.
   assign put_newline = (char_ff == NEWLINE_CODE);
   assign put_wrap    = put_newline || (cur_col_ff == LAST_COL);
   assign put_scroll  = put_wrap && (cur_row_ff == LAST_ROW);

   always_comb begin
      cur_row_in  = cur_row_ff;
      cur_col_in  = cur_col_ff;
      cur_addr_in = cur_addr_ff;
      row_base_in = row_base_ff;
      case (ctrl.cur_op)
         CUR_PUT: begin
            if (put_scroll) begin
               cur_row_in  = LAST_ROW;
               cur_col_in  = '0;
               cur_addr_in = LAST_ROW_BASE;
               row_base_in = LAST_ROW_BASE;
            end else if (put_wrap) begin
               cur_row_in  = cur_row_ff + 1'b1;
               cur_col_in  = '0;
               cur_addr_in = row_base_ff + ROW_STEP;
               row_base_in = row_base_ff + ROW_STEP;
            end else begin
               cur_col_in  = cur_col_ff + 1'b1;
               cur_addr_in = cur_addr_ff + 1'b1;
            end
         end
         CUR_HOME: begin
            cur_row_in  = '0;
            cur_col_in  = '0;
            cur_addr_in = '0;
            row_base_in = '0;
         end
         default: ;
      endcase
   end

   // Walk pointer for fills, copies and blanking.
   always_comb begin
      ptr_in = ptr_ff;
      case (ctrl.ptr_op)
         PTR_ZERO:      ptr_in = '0;
         PTR_INC:       ptr_in = ptr_ff + 1'b1;
         PTR_SRC_START: ptr_in = ROW_STEP;
         PTR_LAST_ROW:  ptr_in = LAST_ROW_BASE;
         default:       ptr_in = ptr_ff;
      endcase
   end

   // Read cell address; out-of-screen reads return zero.
   assign rd_in_range = (32'(read_row_ff) < ROWS) && (32'(read_col_ff) < COLUMNS);
   assign cell_addr   = AW'(32'(read_row_ff) * COLUMNS + 32'(read_col_ff));

   // Write port: a newline stores nothing, a copy writes only once its read is back.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = ptr_ff;
      ram_wr_data = '0;
      case (ctrl.wr_sel)
         WR_RESET_BLANK: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = RESET_BLANK_CELL;
         end
         WR_ATTR_BLANK: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = {attr_ff, SPACE_CODE};
         end
         WR_CHAR: begin
            ram_wr_en   = !put_newline;
            ram_wr_addr = cur_addr_ff;
            ram_wr_data = {attr_ff, char_ff};
         end
         WR_COPY: begin
            ram_wr_en   = copy_pend_ff;
            ram_wr_addr = dst_ff;
            ram_wr_data = ram_rd_data;
         end
         default: ;
      endcase
   end

   assign ram_rd_addr = (ctrl.rd_sel == RD_CELL) ? cell_addr : ptr_ff;

   tcw_ram #(
      .WIDTH (16),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // CSR: one register, decoded on the word address bit.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == CSR_TEXT_ATTRIBUTE);
   assign csr_prdata = (csr_paddr[2] == CSR_TEXT_ATTRIBUTE) ? {24'd0, attr_ff} : 32'd0;

   assign rsp_row_wide = {5'd0, cur_row_ff};
   assign rsp_col_wide = {7'd0, cur_col_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= TEXT_ATTR_RESET;
         ptr_ff       <= '0;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         cur_addr_ff  <= '0;
         row_base_ff  <= '0;
         scrolled_ff  <= 1'b0;
         copy_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            attr_ff <= csr_pwdata[7:0];
         end
         ptr_ff       <= ptr_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         cur_addr_ff  <= cur_addr_in;
         row_base_ff  <= row_base_in;
         copy_pend_ff <= ctrl.copy_rd;
         // Clear the flag on a new request, raise it when the put scrolls.
         if (req_fire) begin
            scrolled_ff <= 1'b0;
         end else if (ctrl.cur_op == CUR_PUT) begin
            scrolled_ff <= put_scroll;
         end
         if (emit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      dst_ff <= ptr_ff - ROW_STEP;
      if (req_fire) begin
         char_ff     <= req_char;
         read_row_ff <= req_row;
         read_col_ff <= req_col;
         cell_ff     <= '0;
      end else if (ctrl.load_cell) begin
         cell_ff <= rd_in_range ? ram_rd_data : 16'd0;
      end
      if (emit_fire) begin
         rsp_data_ff <= {3'd0, scrolled_ff, rsp_col_wide[6:0], rsp_row_wide[4:0], cell_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_cursor_in_screen: assert property (@(posedge clock) disable iff (reset)
      (cur_row_ff <= LAST_ROW) && (cur_col_ff <= LAST_COL))
      else $error("cursor left the screen");

   a_cursor_addr_tracks: assert property (@(posedge clock) disable iff (reset)
      (row_base_ff == AW'(32'(cur_row_ff) * COLUMNS)) &&
      (cur_addr_ff == row_base_ff + AW'(cur_col_ff)))
      else $error("cursor address out of step with row and column");

   a_copy_only_in_scroll: assert property (@(posedge clock) disable iff (reset)
      copy_pend_ff |-> (ctrl.wr_sel == WR_COPY))
      else $error("copied cell read back outside the scroll copy");

   a_no_accept_while_copying: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !copy_pend_ff && (ctrl.wr_sel == WR_NONE))
      else $error("request taken while the screen is being written");
`endif

endmodule

`default_nettype wire

@@ sv/tcw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ sv/tcw_sequencer.sv @@
// Step counter, microcode fetch and branch logic.
`timescale 1ns / 1ps
`default_nettype none

module tcw_sequencer (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tcw_pkg::status_type    status,
   output tcw_pkg::ctrl_word_type      ctrl
);

   import tcw_pkg::*;

   step_type step_ff;
   step_type step_in;
   step_type step_next;

   assign ctrl      = ucode_rom(step_ff);
   assign step_next = step_type'(4'(step_ff) + 4'd1);

   always_comb begin
      step_in = step_ff;
      unique case (ctrl.br)
         BR_NEXT:     step_in = step_next;
         BR_GOTO:     step_in = ctrl.target;
         BR_LOOP:     step_in = status.ptr_last ? ctrl.target : step_ff;
         BR_DISPATCH: step_in = status.req_valid ? dispatch_step(status.kind) : step_ff;
         BR_SCROLL:   step_in = status.scroll ? ctrl.target : step_next;
         BR_EMIT:     step_in = status.out_free ? ctrl.target : step_ff;
         default:     step_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_INIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

@@ test/text_console_writer_tb.sv @@
// Self-checking testbench for the text console writer: screen mirror, stream driver and monitor.
`timescale 1ns / 1ps

module text_console_writer_tb;
   import tcw_pkg::*;

   localparam int SCREEN_COLS      = 80;
   localparam int SCREEN_ROWS      = 25;
   localparam int SCREEN_CELLS     = SCREEN_COLS * SCREEN_ROWS;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int PHASE_SETTLE     = 16;
   // The slowest request is a put that scrolls, which sweeps the whole screen; allow two sweeps.
   localparam int END_SETTLE       = 2 * SCREEN_CELLS + 100;
   // Quiet time allowed: clearing pass, a scroll, the long receiver hold and a long gap.
   localparam int WATCHDOG_LIMIT   = 20000;
   localparam int MAX_REPORTS      = 40;

   // Request fields, first field in the lowest bits.
   typedef struct packed {
      logic [6:0] read_col;
      logic [4:0] read_row;
      logic [7:0] char_code;
      kind_type   kind;
   } console_req_type;

   // Reply fields, first field in the lowest bits.
   typedef struct packed {
      logic       scrolled;
      logic [6:0] cursor_col;
      logic [4:0] cursor_row;
      logic [15:0] cell_value;
   } console_rsp_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Commands waiting for the driver, and replies the screen mirror has promised.
   console_req_type pending_commands[$];
   console_rsp_type expected_replies[$];

   // Mirror of the screen, cursor and attribute register.
   logic [15:0] mirror_cells [0:SCREEN_CELLS-1];
   logic [4:0]  mirror_row;
   logic [6:0]  mirror_col;
   logic [7:0]  mirror_attr;

   console_rsp_type predicted_reply;
   logic         req_took      = 1'b0;
   int unsigned  req_gap       = 0;
   int unsigned  req_calm      = 0;
   int unsigned  req_roll;
   int unsigned  rsp_hold      = 0;
   int unsigned  rsp_calm      = 0;
   int unsigned  rsp_roll;
   int unsigned  hold_requests = 0;
   int unsigned  hold_served   = 0;
   logic         sender_eager  = 1'b0;
   int unsigned  quiet_cycles  = 0;
   int unsigned  mismatch_count = 0;
   int unsigned  replies_seen  = 0;

   text_console_writer #(
      .COLUMNS(SCREEN_COLS),
      .ROWS   (SCREEN_ROWS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #10;
      clock = 1'b1;
      #10;
      clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Screen mirror: apply one accepted request, return the reply it owes.
   // ------------------------------------------------------------------
   task automatic advance_screen_model(input console_req_type cmd,
                                       output console_rsp_type reply);
      int          row;
      int          col;
      int          idx;
      logic [15:0] blank;
      reply = '0;
      blank = {mirror_attr, SPACE_CODE};
      case (cmd.kind)
         KIND_PUT: begin
            row = int'(mirror_row);
            col = int'(mirror_col);
            if (cmd.char_code == NEWLINE_CODE) begin
               row = row + 1;
               col = 0;
            end else begin
               mirror_cells[row * SCREEN_COLS + col] = {mirror_attr, cmd.char_code};
               col = col + 1;
               // Wrap past the last column onto the next row.
               if (col >= SCREEN_COLS) begin
                  col = 0;
                  row = row + 1;
               end
            end
            // Past the bottom row: shift everything up one row, blank the bottom row.
            if (row >= SCREEN_ROWS) begin
               for (idx = 0; idx < SCREEN_CELLS - SCREEN_COLS; idx++)
                  mirror_cells[idx] = mirror_cells[idx + SCREEN_COLS];
               for (idx = SCREEN_CELLS - SCREEN_COLS; idx < SCREEN_CELLS; idx++)
                  mirror_cells[idx] = blank;
               row = SCREEN_ROWS - 1;
               reply.scrolled = 1'b1;
            end
            mirror_row = 5'(row);
            mirror_col = 7'(col);
         end
         KIND_READ: begin
            // Reads outside the screen return zero.
            if (int'(cmd.read_row) < SCREEN_ROWS && int'(cmd.read_col) < SCREEN_COLS)
               reply.cell_value =
                  mirror_cells[int'(cmd.read_row) * SCREEN_COLS + int'(cmd.read_col)];
         end
         KIND_CLEAR: begin
            for (idx = 0; idx < SCREEN_CELLS; idx++)
               mirror_cells[idx] = blank;
            mirror_row = '0;
            mirror_col = '0;
         end
         default: begin
            // Unused kind leaves everything alone.
         end
      endcase
      reply.cursor_row = mirror_row;
      reply.cursor_col = mirror_col;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] seen,
                                  input logic [31:0] wanted);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch in %s at reply %0d: got %h, want %h",
                  what, replies_seen, seen, wanted);
   endtask

   task automatic check_reply(input console_rsp_type got);
      console_rsp_type want;
      if (expected_replies.size() == 0) begin
         report_mismatch("reply with no request outstanding", 32'(got), '0);
         return;
      end
      want = expected_replies.pop_front();
      if (got.cell_value !== want.cell_value)
         report_mismatch("cell_value", 32'(got.cell_value), 32'(want.cell_value));
      if (got.cursor_row !== want.cursor_row)
         report_mismatch("cursor_row", 32'(got.cursor_row), 32'(want.cursor_row));
      if (got.cursor_col !== want.cursor_col)
         report_mismatch("cursor_col", 32'(got.cursor_col), 32'(want.cursor_col));
      if (got.scrolled !== want.scrolled)
         report_mismatch("scrolled", 32'(got.scrolled), 32'(want.scrolled));
   endtask

   // ------------------------------------------------------------------
   // Monitor: sample both handshakes and the CSR write at the rising edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      req_took <= !reset && req_tvalid && req_tready;
      if (reset) begin
         for (int i = 0; i < SCREEN_CELLS; i++)
            mirror_cells[i] = RESET_BLANK_CELL;
         mirror_row  = '0;
         mirror_col  = '0;
         mirror_attr = TEXT_ATTR_RESET;
      end else begin
         // Check first: a request taken at this edge cannot answer at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            replies_seen++;
            check_reply(rsp_tdata[28:0]);
         end
         if (req_tvalid && req_tready) begin
            advance_screen_model(req_tdata[21:0], predicted_reply);
            expected_replies.push_back(predicted_reply);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready === 1'b1 &&
             csr_paddr == {CSR_TEXT_ATTRIBUTE, 2'b00})
            mirror_attr = csr_pwdata[7:0];
      end
   end

   // ------------------------------------------------------------------
   // Driver: present the next pending request at the falling edge,
   // with random gaps unless the sender is told to push hard.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (req_gap > 0 && !sender_eager) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_commands.size() > 0) begin
            req_tdata  <= {2'b00, pending_commands.pop_front()};
            req_tvalid <= 1'b1;
            req_roll = $urandom_range(0, 99);
            if (req_calm > 0) begin
               req_calm--;
               req_gap = 0;
            end else if (req_roll < 60) begin
               req_gap = 0;
            end else if (req_roll < 90) begin
               req_gap = $urandom_range(1, 3);
            end else if (req_roll < 97) begin
               req_gap = $urandom_range(8, 40);
            end else begin
               // Back-to-back stretch.
               req_calm = $urandom_range(20, 80);
               req_gap  = 0;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random stalls, an occasional long hold on request.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         rsp_hold    = LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (rsp_calm > 0) begin
         rsp_calm--;
         rsp_tready <= 1'b1;
      end else begin
         rsp_roll = $urandom_range(0, 99);
         if (rsp_roll < 70) begin
            rsp_tready <= 1'b1;
         end else if (rsp_roll < 93) begin
            rsp_hold = $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else if (rsp_roll < 97) begin
            rsp_hold = $urandom_range(10, 60);
            rsp_tready <= 1'b0;
         end else begin
            rsp_calm = $urandom_range(30, 150);
            rsp_tready <= 1'b1;
         end
      end
   end

   // Drop the run if nothing moves on either stream for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic console_req_type make_command(input kind_type k, input logic [7:0] ch,
                                                    input logic [4:0] row,
                                                    input logic [6:0] col);
      console_req_type cmd;
      cmd.kind      = k;
      cmd.char_code = ch;
      cmd.read_row  = row;
      cmd.read_col  = col;
      return cmd;
   endfunction

   function automatic logic [7:0] random_glyph();
      if ($urandom_range(0, 99) < 80)
         return 8'($urandom_range(8'h20, 8'h7E));
      return 8'($urandom_range(0, 255));
   endfunction

   // Put a character; the unused read fields carry random noise.
   task automatic push_put(input logic [7:0] ch);
      pending_commands.push_back(make_command(KIND_PUT, ch, 5'($urandom), 7'($urandom)));
   endtask

   task automatic push_read(input int row, input int col);
      pending_commands.push_back(make_command(KIND_READ, 8'($urandom), 5'(row), 7'(col)));
   endtask

   // Build realistic console traffic: lines of text ending in newline, long runs
   // that wrap, bursts of newlines that drive into scrolling, reads, rare clears
   // and a little junk of the unused kind.
   task automatic queue_random_session(input int target);
      int base;
      int roll;
      int len;
      int n;
      base = pending_commands.size();
      while (pending_commands.size() - base < target) begin
         roll = $urandom_range(0, 99);
         if (roll < 50) begin
            len = $urandom_range(0, 30);
            for (n = 0; n < len; n++)
               push_put(random_glyph());
            push_put(NEWLINE_CODE);
         end else if (roll < 54) begin
            len = $urandom_range(SCREEN_COLS + 1, 2 * SCREEN_COLS + 10);
            for (n = 0; n < len; n++)
               push_put(8'($urandom_range(8'h21, 8'h7E)));
         end else if (roll < 76) begin
            len = $urandom_range(1, 6);
            for (n = 0; n < len; n++) begin
               if ($urandom_range(0, 99) < 85)
                  push_read($urandom_range(0, SCREEN_ROWS - 1),
                            $urandom_range(0, SCREEN_COLS - 1));
               else
                  push_read($urandom_range(0, 31), $urandom_range(0, 127));
            end
         end else if (roll < 88) begin
            len = $urandom_range(1, 4);
            for (n = 0; n < len; n++)
               push_put(NEWLINE_CODE);
         end else if (roll < 99) begin
            len = $urandom_range(1, 2);
            for (n = 0; n < len; n++)
               pending_commands.push_back(make_command(KIND_NONE, 8'($urandom),
                                                       5'($urandom), 7'($urandom)));
         end else begin
            pending_commands.push_back(make_command(KIND_CLEAR, 8'($urandom),
                                                    5'($urandom), 7'($urandom)));
         end
      end
   endtask

   // Hold until every request has gone out and every reply has come back.
   task automatic wait_drained(input int settle);
      do
         @(posedge clock);
      while (pending_commands.size() != 0 || req_tvalid || expected_replies.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   // APB write of the attribute register: setup cycle, then access cycle.
   task automatic write_attribute(input logic [7:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {CSR_TEXT_ATTRIBUTE, 2'b00};
      csr_pwdata  <= {24'h0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      // Directed part under the reset attribute: reset screen contents,
      // reads off the screen edge, extreme characters, unused kind, clear.
      push_read(0, 0);
      push_read(SCREEN_ROWS - 1, SCREEN_COLS - 1);
      push_read(31, 127);
      push_read(SCREEN_ROWS, 0);
      push_read(0, SCREEN_COLS);
      push_put(8'h00);
      push_put(8'hFF);
      push_put(8'h41);
      push_read(0, 0);
      push_read(0, 1);
      pending_commands.push_back(make_command(KIND_NONE, 8'hFF, 5'h1F, 7'h7F));
      push_put(NEWLINE_CODE);
      push_put(8'h7E);
      push_read(1, 0);
      pending_commands.push_back(make_command(KIND_CLEAR, 8'h00, 5'h00, 7'h00));
      push_read(0, 0);
      push_read(0, 2);

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      wait_drained(PHASE_SETTLE);
      write_attribute(8'hFF);
      // Clear and write under the all-ones attribute.
      pending_commands.push_back(make_command(KIND_CLEAR, 8'hFF, 5'h1F, 7'h7F));
      push_put(8'h5A);
      push_read(0, 0);
      push_read(SCREEN_ROWS - 1, SCREEN_COLS - 1);
      queue_random_session(170);

      wait_drained(PHASE_SETTLE);
      write_attribute(8'h00);
      queue_random_session(170);

      // Back up the block: receiver holds off while the sender pushes hard.
      wait_drained(PHASE_SETTLE);
      write_attribute(8'($urandom));
      queue_random_session(170);
      @(posedge clock);
      sender_eager = 1'b1;
      hold_requests++;
      repeat (LONG_HOLD_CYCLES + 50) @(posedge clock);
      sender_eager = 1'b0;

      wait_drained(PHASE_SETTLE);
      write_attribute(8'h1E);
      queue_random_session(170);

      wait_drained(PHASE_SETTLE);
      write_attribute(8'($urandom));
      queue_random_session(170);

      // Give any stray reply time to show up before the verdict.
      wait_drained(END_SETTLE);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_sequencer.sv
sv/text_console_writer.sv
test/text_console_writer_tb.sv
